[design/dfss_pkg.sv]
package dfss_pkg;

  localparam int unsigned DriveSlotsDefault = 8;
  localparam int unsigned SlotW             = 3;
  localparam int unsigned SlotSpan          = 1 << SlotW;

  // Queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  // Speed estimate: 32b diff times 1000 gives a 42b signed product,
  // divided two quotient bits per cycle.
  localparam int unsigned ProdW    = 42;
  localparam int unsigned DivSteps = ProdW / 2;
  localparam int unsigned DivCntW  = 5;
  localparam logic signed [10:0] SpeedScale = 11'sd1000;
  localparam logic [ProdW-1:0] SatPosMag = 42'h0007fffffff;
  localparam logic [ProdW-1:0] SatNegMag = 42'h00080000000;
  localparam logic [31:0] SpeedMax = 32'h7fffffff;
  localparam logic [31:0] SpeedMin = 32'h80000000;

  // Status word classification
  localparam logic [15:0] MaskSix        = 16'h006f;
  localparam logic [15:0] MaskFour       = 16'h004f;
  localparam logic [15:0] StOpEnabled    = 16'h0027;
  localparam logic [15:0] StQuickStop    = 16'h0007;
  localparam logic [15:0] StFault        = 16'h0008;
  localparam logic [15:0] StSwitchedOn   = 16'h0023;
  localparam logic [15:0] StReadyOn      = 16'h0021;
  localparam logic [15:0] StOnDisabled   = 16'h0040;

  // Outgoing frames
  localparam logic [10:0] IdControl   = 11'h200;
  localparam logic [10:0] IdCommand   = 11'h300;
  localparam logic [2:0]  LenControl  = 3'd2;
  localparam logic [2:0]  LenCommand  = 3'd5;
  localparam logic [7:0]  CwEnableOp  = 8'h0f;
  localparam logic [7:0]  CwSwitchOn  = 8'h07;
  localparam logic [7:0]  CmdEnable   = 8'h0f;
  localparam logic [7:0]  CmdSetSpeed = 8'h93;

  typedef enum logic [1:0] {
    CMD_FEEDBACK = 2'd0,
    CMD_STATUS   = 2'd1,
    CMD_SPEED    = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_NONE     = 2'd0,
    OP_FEEDBACK = 2'd1,
    OP_STATUS   = 2'd2
  } op_e;

  // One classified item, as queued for the back end
  typedef struct packed {
    op_e              op;
    logic             ok;
    logic [SlotW-1:0] slot;
    logic [31:0]      position;
    logic [15:0]      current;
    logic [7:0]       interval;
    logic [15:0]      drv_status;
    logic             send_frame;
    logic [10:0]      frame_id;
    logic [2:0]       frame_length;
    logic [39:0]      frame_data;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

endpackage

[design/dfss_if.sv]
interface dfss_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [2:0]         slot;
  logic [6:0]         node_id;
  logic [31:0]        position;
  logic [15:0]        current;
  logic [7:0]         interval;
  logic [15:0]        drv_status;
  logic signed [31:0] speed_target;

  modport source (
    output valid, cmd, slot, node_id, position, current, interval, drv_status,
           speed_target,
    input  ready
  );
  modport sink (
    input  valid, cmd, slot, node_id, position, current, interval, drv_status,
           speed_target,
    output ready
  );
endinterface

interface dfss_out_if;
  logic               valid;
  logic               ready;
  logic               send_frame;
  logic [10:0]        frame_id;
  logic [2:0]         frame_length;
  logic [39:0]        frame_data;
  logic signed [31:0] motor_speed;
  logic [31:0]        motor_position;
  logic [15:0]        motor_current;
  logic [15:0]        motor_status;

  modport source (
    output valid, send_frame, frame_id, frame_length, frame_data, motor_speed,
           motor_position, motor_current, motor_status,
    input  ready
  );
  modport sink (
    input  valid, send_frame, frame_id, frame_length, frame_data, motor_speed,
           motor_position, motor_current, motor_status,
    output ready
  );
endinterface

[design/dfss_fifo.sv]
module dfss_fifo import dfss_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  job_t  wr_data_i,
  input  logic  push_i,
  output logic  full_o,
  output logic  valid_o,
  output job_t  rd_data_o,
  input  logic  pop_i
);

  job_t                 buf_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o    = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = buf_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[design/dfss_front.sv]
module dfss_front import dfss_pkg::*; #(
  parameter int unsigned DRIVE_SLOTS = DriveSlotsDefault
) (
  dfss_in_if.sink in_i,
  output qctl_t   qctl_o,
  input  logic    full_i,
  output job_t    job_o
);

  logic [15:0] m6, m4;
  logic        ok;

  assign m6 = in_i.drv_status & MaskSix;
  assign m4 = in_i.drv_status & MaskFour;
  assign ok = (32'(in_i.slot) < DRIVE_SLOTS);

  assign in_i.ready  = !full_i;
  assign qctl_o.push = in_i.valid && !full_i;
  assign qctl_o.full = full_i;

  always_comb begin
    job_o              = '0;
    job_o.op           = OP_NONE;
    job_o.ok           = ok;
    job_o.slot         = in_i.slot;
    job_o.position     = in_i.position;
    job_o.current      = in_i.current;
    job_o.interval     = in_i.interval;
    job_o.drv_status   = in_i.drv_status;
    unique case (cmd_e'(in_i.cmd))
      CMD_FEEDBACK: begin
        job_o.op = OP_FEEDBACK;
      end
      CMD_STATUS: begin
        job_o.op = OP_STATUS;
        if (m6 == StOpEnabled || m6 == StQuickStop || m4 == StFault) begin
          job_o.send_frame = 1'b0;
        end else if (m6 == StSwitchedOn) begin
          job_o.send_frame   = 1'b1;
          job_o.frame_id     = IdControl + {4'b0, in_i.node_id};
          job_o.frame_length = LenControl;
          job_o.frame_data   = {32'b0, CwEnableOp};
        end else if (m6 == StReadyOn) begin
          job_o.send_frame   = 1'b1;
          job_o.frame_id     = IdControl + {4'b0, in_i.node_id};
          job_o.frame_length = LenControl;
          job_o.frame_data   = {32'b0, CwSwitchOn};
        end else if (m4 == StOnDisabled) begin
          job_o.send_frame   = 1'b1;
          job_o.frame_id     = IdCommand + {4'b0, in_i.node_id};
          job_o.frame_length = LenCommand;
          job_o.frame_data   = {32'b0, CmdEnable};
        end
      end
      CMD_SPEED: begin
        job_o.send_frame   = 1'b1;
        job_o.frame_id     = IdCommand + {4'b0, in_i.node_id};
        job_o.frame_length = LenCommand;
        job_o.frame_data   = {in_i.speed_target, CmdSetSpeed};
      end
      CMD_UNUSED: begin
        job_o.op = OP_NONE;
      end
    endcase
  end

endmodule

[design/dfss_back.sv]
module dfss_back import dfss_pkg::*; #(
  parameter int unsigned DRIVE_SLOTS = DriveSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  job_t        q_data_i,
  output logic        q_pop_o,
  dfss_out_if.source  out_o
);

  localparam int unsigned SlotDepth = (DRIVE_SLOTS < SlotSpan) ? DRIVE_SLOTS : SlotSpan;
  localparam int unsigned IdxW      = (SlotDepth > 1) ? $clog2(SlotDepth) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ABS  = 5'b00100,
    S_DIV  = 5'b01000,
    S_WB   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  job_t   job_q;

  // Per-slot drive state
  logic [31:0] pos_q   [SlotDepth];
  logic [31:0] speed_q [SlotDepth];
  logic [15:0] cur_q   [SlotDepth];
  logic [15:0] stat_q  [SlotDepth];

  logic signed [ProdW-1:0] prod_q;
  logic [ProdW-1:0]        dvd_q;
  logic [7:0]              rem_q;
  logic                    neg_q;
  logic [DivCntW-1:0]      cnt_q;

  logic [IdxW-1:0] idx;
  logic [31:0]     diff;
  logic [8:0]      r1, r2, dv9;
  logic            ge1, ge2;
  logic [7:0]      r1n, r2n;
  logic [ProdW-1:0] mag_neg;
  logic [31:0]     speed_sat;
  logic            use_div, do_wb, do_write;
  logic [31:0]     new_speed, new_pos;
  logic [15:0]     new_cur, new_stat;

  logic        out_valid_q;
  logic        send_q;
  logic [10:0] id_q;
  logic [2:0]  len_q;
  logic [39:0] data_q;
  logic [31:0] mspeed_q, mpos_q;
  logic [15:0] mcur_q, mstat_q;

  assign idx  = job_q.slot[IdxW-1:0];
  assign diff = job_q.position - pos_q[idx];

  // Two restoring-division steps per cycle
  assign dv9 = {1'b0, job_q.interval};
  assign r1  = {rem_q, dvd_q[ProdW-1]};
  assign ge1 = (r1 >= dv9);
  assign r1n = ge1 ? 8'(r1 - dv9) : r1[7:0];
  assign r2  = {r1n, dvd_q[ProdW-2]};
  assign ge2 = (r2 >= dv9);
  assign r2n = ge2 ? 8'(r2 - dv9) : r2[7:0];

  // Sign and saturate the quotient magnitude
  assign mag_neg = -dvd_q;
  always_comb begin
    if (neg_q) begin
      speed_sat = (dvd_q > SatNegMag) ? SpeedMin : mag_neg[31:0];
    end else begin
      speed_sat = (dvd_q > SatPosMag) ? SpeedMax : dvd_q[31:0];
    end
  end

  assign use_div  = (job_q.op == OP_FEEDBACK) && job_q.ok && (job_q.interval != '0);
  assign do_wb    = (state_q == S_WB) && (!out_valid_q || out_o.ready);
  assign do_write = do_wb && job_q.ok;

  always_comb begin
    new_speed = speed_q[idx];
    new_pos   = pos_q[idx];
    new_cur   = cur_q[idx];
    new_stat  = stat_q[idx];
    case (job_q.op)
      OP_FEEDBACK: begin
        if (use_div) begin
          new_speed = speed_sat;
        end
        new_pos = job_q.position;
        new_cur = job_q.current;
      end
      OP_STATUS: new_stat = job_q.drv_status;
      default:   new_stat = stat_q[idx];
    endcase
  end

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          if (q_data_i.op == OP_FEEDBACK && q_data_i.ok && q_data_i.interval != '0) begin
            state_d = S_MUL;
          end else begin
            state_d = S_WB;
          end
        end
      end
      S_MUL: state_d = S_ABS;
      S_ABS: state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == '0) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        if (do_wb) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SlotDepth; i++) begin
        pos_q[i]   <= '0;
        speed_q[i] <= '0;
        cur_q[i]   <= '0;
        stat_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (do_wb) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (do_write) begin
        pos_q[idx]   <= new_pos;
        speed_q[idx] <= new_speed;
        cur_q[idx]   <= new_cur;
        stat_q[idx]  <= new_stat;
      end
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_data_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= ProdW'($signed(diff)) * ProdW'(SpeedScale);
    end
    if (state_q == S_ABS) begin
      neg_q <= prod_q[ProdW-1];
      dvd_q <= prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
      rem_q <= '0;
      cnt_q <= DivCntW'(DivSteps - 1);
    end
    if (state_q == S_DIV) begin
      dvd_q <= {dvd_q[ProdW-3:0], ge1, ge2};
      rem_q <= r2n;
      cnt_q <= cnt_q - 1'b1;
    end
    if (do_wb) begin
      send_q   <= job_q.send_frame;
      id_q     <= job_q.frame_id;
      len_q    <= job_q.frame_length;
      data_q   <= job_q.frame_data;
      mspeed_q <= job_q.ok ? new_speed : '0;
      mpos_q   <= job_q.ok ? new_pos : '0;
      mcur_q   <= job_q.ok ? new_cur : '0;
      mstat_q  <= job_q.ok ? new_stat : '0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.send_frame     = send_q;
  assign out_o.frame_id       = id_q;
  assign out_o.frame_length   = len_q;
  assign out_o.frame_data     = data_q;
  assign out_o.motor_speed    = $signed(mspeed_q);
  assign out_o.motor_position = mpos_q;
  assign out_o.motor_current  = mcur_q;
  assign out_o.motor_status   = mstat_q;

`ifndef SYNTHESIS
  a_load_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_WB))
    else $error("result loaded outside write-back");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (job_q.interval != '0))
    else $error("divider running with zero interval");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == '0) |=> (state_q == S_WB))
    else $error("divider did not hand off to write-back");
`endif

endmodule

[design/drive_feedback_and_state_supervisor_top.sv]
// Path: an item is written into the queue and popped into the back end's job
//   register; a feedback item for a valid slot and a nonzero interval then runs
//   multiply, abs and a 2-bit-per-cycle divide (21 steps over a 42-bit product).
// The back end takes no new item until the last result is written back.
// Reset (rst_ni, async, active low): all slot state cleared to zero at once,
//   queue emptied, no result pending.
module drive_feedback_and_state_supervisor_top import dfss_pkg::*; #(
  parameter int unsigned DRIVE_SLOTS = DriveSlotsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dfss_in_if.sink    in_i,
  dfss_out_if.source out_o
);

  // Front end: decodes the command, decides the frame from the item's own
  // fields and checks the slot against the configured slot count.
  qctl_t qctl;
  job_t  front_job;

  // Two-entry queue lets the front keep accepting while the back divides.
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  job_t  q_job;

  dfss_front #(
    .DRIVE_SLOTS (DRIVE_SLOTS)
  ) u_front (
    .in_i   (in_i),
    .qctl_o (qctl),
    .full_i (q_full),
    .job_o  (front_job)
  );

  dfss_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_data_i (front_job),
    .push_i    (qctl.push),
    .full_o    (q_full),
    .valid_o   (q_valid),
    .rd_data_o (q_job),
    .pop_i     (q_pop)
  );

  // Back end: per-slot state, speed estimate (multiply, iterative divide,
  // saturate), write-back and the output register.
  dfss_back #(
    .DRIVE_SLOTS (DRIVE_SLOTS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_job),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

[tb/sv/dfss_checker.sv]
`timescale 1ns / 100ps

// Watches both channels, keeps its own copy of the per-slot drive state and
// compares every result with the oldest outstanding prediction.
module dfss_checker import dfss_pkg::*; #(
  parameter int unsigned DRIVE_SLOTS = DriveSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dfss_in_if          in_mon_i,
  dfss_out_if         out_mon_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam int unsigned ReportLimit = 40;

  typedef struct {
    logic        send_frame;
    logic [10:0] frame_id;
    logic [2:0]  frame_length;
    logic [39:0] frame_data;
    logic [31:0] motor_speed;
    logic [31:0] motor_position;
    logic [15:0] motor_current;
    logic [15:0] motor_status;
  } drive_report_t;

  logic [31:0] slot_position [SlotSpan];
  logic [31:0] slot_speed    [SlotSpan];
  logic [15:0] slot_current  [SlotSpan];
  logic [15:0] slot_status   [SlotSpan];
  drive_report_t report_q [$];

  // wrapped position delta, scaled by 1000, truncating divide, saturated
  function automatic logic [31:0] next_speed(input logic [31:0] now, input logic [31:0] prev,
                                             input logic [7:0] divisor,
                                             input logic [31:0] old);
    logic [31:0] delta;
    longint      diff;
    longint      dv;
    longint      quot;
    if (divisor == 8'd0) return old;
    delta = now - prev;
    diff  = longint'($signed(delta));
    dv    = {56'd0, divisor};
    quot  = (diff * 64'sd1000) / dv;
    if (quot > 64'sd2147483647) return SpeedMax;
    if (quot < -64'sd2147483648) return SpeedMin;
    return quot[31:0];
  endfunction

  task automatic predict_item();
    drive_report_t r;
    logic [2:0]    s;
    logic          ok;
    logic [10:0]   node;
    logic [15:0]   sw;
    logic [15:0]   m6;
    logic [15:0]   m4;
    r    = '{default: '0};
    s    = in_mon_i.slot;
    ok   = 32'(s) < DRIVE_SLOTS;
    node = 11'(in_mon_i.node_id);
    case (cmd_e'(in_mon_i.cmd))
      CMD_FEEDBACK: begin
        if (ok) begin
          slot_speed[s]    = next_speed(in_mon_i.position, slot_position[s],
                                        in_mon_i.interval, slot_speed[s]);
          slot_position[s] = in_mon_i.position;
          slot_current[s]  = in_mon_i.current;
        end
      end
      CMD_STATUS: begin
        sw = in_mon_i.drv_status;
        m6 = sw & MaskSix;
        m4 = sw & MaskFour;
        if (ok) slot_status[s] = sw;
        if (m6 == StOpEnabled || m6 == StQuickStop || m4 == StFault) begin
          // running, quick stop or fault: drive is left alone
        end else if (m6 == StSwitchedOn) begin
          r.send_frame   = 1'b1;
          r.frame_id     = IdControl + node;
          r.frame_length = LenControl;
          r.frame_data   = 40'(CwEnableOp);
        end else if (m6 == StReadyOn) begin
          r.send_frame   = 1'b1;
          r.frame_id     = IdControl + node;
          r.frame_length = LenControl;
          r.frame_data   = 40'(CwSwitchOn);
        end else if (m4 == StOnDisabled) begin
          r.send_frame   = 1'b1;
          r.frame_id     = IdCommand + node;
          r.frame_length = LenCommand;
          r.frame_data   = 40'(CmdEnable);
        end
      end
      CMD_SPEED: begin
        r.send_frame   = 1'b1;
        r.frame_id     = IdCommand + node;
        r.frame_length = LenCommand;
        r.frame_data   = {in_mon_i.speed_target, CmdSetSpeed};
      end
      default: begin
        // unused command: no frame, no state change
      end
    endcase
    if (ok) begin
      r.motor_speed    = slot_speed[s];
      r.motor_position = slot_position[s];
      r.motor_current  = slot_current[s];
      r.motor_status   = slot_status[s];
    end
    report_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatch_cnt_o++;
      if (mismatch_cnt_o <= ReportLimit)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    drive_report_t want;
    if (!rst_ni) begin
      foreach (slot_position[i]) begin
        slot_position[i] = '0;
        slot_speed[i]    = '0;
        slot_current[i]  = '0;
        slot_status[i]   = '0;
      end
      report_q.delete();
      mismatch_cnt_o = 0;
      checked_o      = 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) predict_item();
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (report_q.size() == 0) begin
          mismatch_cnt_o++;
          $display("%0t: result with nothing expected, frame_id %0h", $time,
                   out_mon_i.frame_id);
        end else begin
          want = report_q.pop_front();
          checked_o++;
          check_field("send_frame", 64'(want.send_frame), 64'(out_mon_i.send_frame));
          check_field("frame_id", 64'(want.frame_id), 64'(out_mon_i.frame_id));
          check_field("frame_length", 64'(want.frame_length), 64'(out_mon_i.frame_length));
          check_field("frame_data", 64'(want.frame_data), 64'(out_mon_i.frame_data));
          check_field("motor_speed", 64'(want.motor_speed),
                      64'(unsigned'(out_mon_i.motor_speed)));
          check_field("motor_position", 64'(want.motor_position),
                      64'(out_mon_i.motor_position));
          check_field("motor_current", 64'(want.motor_current), 64'(out_mon_i.motor_current));
          check_field("motor_status", 64'(want.motor_status), 64'(out_mon_i.motor_status));
        end
      end
    end
    pending_o = report_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the drive supervisor. Items go in through a bursty
// sender, results are drained by a receiver with its own stall pattern, and
// dfss_checker does all prediction and comparison.
module tb_top;
  import dfss_pkg::*;

  localparam int unsigned DriveSlots  = DriveSlotsDefault;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned HoldCycles  = 300;   // long receiver hold-off
  localparam int unsigned HoldAfter   = 60;    // items sent before the hold-off
  localparam int unsigned IdleLimit   = 4000;  // cycles without any handshake
  localparam int unsigned DrainCycles = 40;    // > slowest item latency

  typedef struct {
    cmd_e               cmd;
    logic [2:0]         slot;
    logic [6:0]         node_id;
    logic [31:0]        position;
    logic [15:0]        current;
    logic [7:0]         interval;
    logic [15:0]        drv_status;
    logic signed [31:0] speed_target;
  } drive_req_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dfss_in_if  in_ch ();
  dfss_out_if out_ch ();

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned checked_cnt;

  // stimulus bookkeeping
  int unsigned items_sent;
  int unsigned cmd_count [4];
  int unsigned burst_left;
  bit          hold_done;
  logic [31:0] pos_hint [SlotSpan];   // last fed position per slot, keeps deltas small

  drive_feedback_and_state_supervisor_top #(
    .DRIVE_SLOTS(DriveSlots)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  dfss_checker #(
    .DRIVE_SLOTS(DriveSlots)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_mon_i      (in_ch),
    .out_mon_i     (out_ch),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending_cnt),
    .checked_o     (checked_cnt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // all fields random; callers override what matters for the item
  function automatic drive_req_t rand_req();
    drive_req_t r;
    r.cmd          = cmd_e'($urandom_range(0, 3));
    r.slot         = 3'($urandom_range(0, 7));
    r.node_id      = 7'($urandom_range(0, 127));
    r.position     = $urandom;
    r.current      = 16'($urandom);
    r.interval     = 8'($urandom);
    r.drv_status   = 16'($urandom);
    r.speed_target = $urandom;
    return r;
  endfunction

  // Drive one item at a falling edge and hold it until accepted. Bursts of
  // random length are separated by random gaps; returns at a falling edge.
  task automatic offer(input drive_req_t r);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      // mostly short bursts, now and then a long back-to-back stretch
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= r.cmd;
    in_ch.slot         <= r.slot;
    in_ch.node_id      <= r.node_id;
    in_ch.position     <= r.position;
    in_ch.current      <= r.current;
    in_ch.interval     <= r.interval;
    in_ch.drv_status   <= r.drv_status;
    in_ch.speed_target <= r.speed_target;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    cmd_count[r.cmd]++;
    @(negedge clk);
  endtask

  task automatic offer_feedback(input logic [2:0] slot, input logic [31:0] pos,
                                input logic [15:0] cur, input logic [7:0] ivl);
    drive_req_t r;
    r          = rand_req();
    r.cmd      = CMD_FEEDBACK;
    r.slot     = slot;
    r.position = pos;
    r.current  = cur;
    r.interval = ivl;
    pos_hint[slot] = pos;
    offer(r);
  endtask

  task automatic offer_status(input logic [2:0] slot, input logic [6:0] node,
                              input logic [15:0] sw);
    drive_req_t r;
    r            = rand_req();
    r.cmd        = CMD_STATUS;
    r.slot       = slot;
    r.node_id    = node;
    r.drv_status = sw;
    offer(r);
  endtask

  task automatic offer_speed(input logic [2:0] slot, input logic [6:0] node,
                             input logic [31:0] spd);
    drive_req_t r;
    r              = rand_req();
    r.cmd          = CMD_SPEED;
    r.slot         = slot;
    r.node_id      = node;
    r.speed_target = spd;
    offer(r);
  endtask

  // status word steered toward one of the drive states, junk in the other bits
  function automatic logic [15:0] pick_status_word();
    logic [15:0] raw;
    raw = 16'($urandom);
    case ($urandom_range(0, 7))
      0:       return (raw & ~MaskSix) | StOpEnabled;
      1:       return (raw & ~MaskSix) | StQuickStop;
      2:       return (raw & ~MaskFour) | StFault;
      3:       return (raw & ~MaskSix) | StSwitchedOn;
      4:       return (raw & ~MaskSix) | StReadyOn;
      5:       return (raw & ~MaskFour) | StOnDisabled;
      default: return raw;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: reset, directed corner items, then random traffic, then drain.
  // ---------------------------------------------------------------------------
  initial begin : sender
    drive_req_t  r;
    int unsigned target;
    int unsigned pick;
    logic [2:0]  s;
    logic [6:0]  node;
    logic [31:0] pos;
    logic [7:0]  ivl;

    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_FEEDBACK;
    in_ch.slot         = '0;
    in_ch.node_id      = '0;
    in_ch.position     = '0;
    in_ch.current      = '0;
    in_ch.interval     = '0;
    in_ch.drv_status   = '0;
    in_ch.speed_target = '0;
    foreach (pos_hint[i]) pos_hint[i] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // -- directed: status decode, every drive state plus precedence cases
    offer_status(3'd0, 7'd0,   16'h0000);   // nothing matches
    offer_status(3'd0, 7'd0,   StOnDisabled);
    offer_status(3'd0, 7'd0,   StReadyOn);
    offer_status(3'd0, 7'd0,   StSwitchedOn);
    offer_status(3'd0, 7'd0,   StOpEnabled);
    offer_status(3'd0, 7'd0,   StQuickStop);
    offer_status(3'd0, 7'd0,   StFault);
    offer_status(3'd0, 7'd0,   16'h0028);   // fault with bit 5 set
    offer_status(3'd7, 7'd127, 16'hffff);   // all bits: nothing
    offer_status(3'd7, 7'd127, 16'hff23);   // switched on, high bits set
    offer_status(3'd7, 7'd127, 16'hffc0);   // disabled needs m4 clean: 0xc0&0x4f=0x40

    // -- directed: speed estimate on slot 1, starting from position zero
    offer_feedback(3'd1, 32'h0000_1234, 16'h0000, 8'd0);    // zero interval keeps speed
    offer_feedback(3'd1, 32'h8000_1234, 16'h8000, 8'd1);    // delta -2^31, clamps low
    offer_feedback(3'd1, 32'hffff_fff0, 16'h0001, 8'd2);    // big positive, clamps high
    offer_feedback(3'd1, 32'h0000_0010, 16'h1234, 8'd255);  // wraps through zero
    offer_feedback(3'd1, 32'h0000_0001, 16'hffff, 8'd7);    // negative, truncates toward zero
    offer_feedback(3'd1, 32'h1234_5678, 16'h5a5a, 8'd0);    // keeps the negative speed
    offer_feedback(3'd7, 32'h0000_03e8, 16'h00ff, 8'd3);

    // -- directed: set speed extremes and the unused command
    offer_speed(3'd2, 7'd127, 32'h7fff_ffff);
    offer_speed(3'd2, 7'd0,   32'h8000_0000);
    offer_speed(3'd3, 7'd64,  32'hffff_ffff);
    offer_speed(3'd3, 7'd1,   32'h0000_0000);
    r     = rand_req();
    r.cmd = CMD_UNUSED;
    offer(r);

    // -- random traffic
    target = items_sent + RandomItems;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      s    = 3'($urandom_range(0, 7));
      node = 7'($urandom_range(0, 127));
      if (pick < 35) begin
        case ($urandom_range(0, 9))
          0:       pos = $urandom;
          1, 2:    pos = pos_hint[s] + ($urandom & 32'h000f_ffff) - 32'h0008_0000;
          default: pos = pos_hint[s] + 32'($urandom_range(0, 4000)) - 32'd2000;
        endcase
        case ($urandom_range(0, 9))
          0:       ivl = 8'd0;
          1:       ivl = 8'd255;
          default: ivl = 8'($urandom_range(1, 255));
        endcase
        offer_feedback(s, pos, 16'($urandom), ivl);
      end else if (pick < 65) begin
        offer_status(s, node, pick_status_word());
      end else if (pick < 80) begin
        offer_speed(s, node, ($urandom_range(0, 9) == 0) ? 32'h8000_0000 : $urandom);
      end else if (pick < 84) begin
        r     = rand_req();
        r.cmd = CMD_UNUSED;
        offer(r);
      end else begin
        // bring-up walk of one drive, then a few feedback frames from it
        offer_status(s, node, (16'($urandom) & ~MaskFour) | StOnDisabled);
        offer_status(s, node, (16'($urandom) & ~MaskSix) | StReadyOn);
        offer_status(s, node, (16'($urandom) & ~MaskSix) | StSwitchedOn);
        offer_status(s, node, (16'($urandom) & ~MaskSix) | StOpEnabled);
        repeat ($urandom_range(1, 3))
          offer_feedback(s, pos_hint[s] + 32'($urandom_range(0, 600)) - 32'd300,
                         16'($urandom), 8'($urandom_range(1, 40)));
      end
    end
    in_ch.valid <= 1'b0;

    // drain: every prediction checked, then let the slowest item clear
    while (pending_cnt != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Sent %0d items: %0d feedback, %0d status, %0d set speed, %0d unused.",
             items_sent, cmd_count[CMD_FEEDBACK], cmd_count[CMD_STATUS],
             cmd_count[CMD_SPEED], cmd_count[CMD_UNUSED]);
    $display("Checked %0d results, %0d mismatches, receiver hold-off %0s.",
             checked_cnt, mismatch_cnt, hold_done ? "done" : "not reached");
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: segments of random stall modes, plus one long hold-off so the
  // internal queue fills and input ready drops while the sender keeps pushing.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned mode;
    int unsigned seg_len;
    int unsigned hold_left;
    logic [7:0]  mask;

    out_ch.ready = 1'b0;
    hold_left    = 0;
    wait (rst_n);
    forever begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(16, 96);
      mask    = 8'($urandom) | 8'h01;
      for (int unsigned k = 0; k < seg_len; k++) begin
        @(negedge clk);
        if (!hold_done && items_sent >= HoldAfter) begin
          hold_done = 1'b1;
          hold_left = HoldCycles;
        end
        if (hold_left != 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else begin
          case (mode)
            0:       out_ch.ready <= 1'b1;                          // no stalls
            1:       out_ch.ready <= 1'($urandom);                  // coin flip
            2:       out_ch.ready <= ($urandom_range(0, 4) == 0);   // mostly stalled
            default: out_ch.ready <= mask[k % 8];                   // fixed pattern
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without a handshake on either channel ends the run.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("Timeout: no handshake for %0d cycles at %0t", idle, $time);
    $display("TB_ERROR");
    $finish;
  end

endmodule
